// ===== hdl/perm_ord_pkg.sv =====
// Shared constants, error codes and divider handshake types for permutation_order.
// No dependencies; imported by perm_ord_div, permutation_order and the bench.
package perm_ord_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int TARGET_W     = 6;
    localparam int TARGET_SPAN  = 1 << TARGET_W;
    localparam int LCM_W        = 64;
    localparam int ERR_W        = 2;
    localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int DIV_STEP_W   = $clog2(LCM_W);

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DUP   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

    typedef struct packed {
        logic               start;
        logic [LCM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LCM_W-1:0]   quotient;
        logic [COUNT_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== hdl/perm_ord_div.sv =====
// Bit-serial restoring divider: 64-bit dividend by a small divisor, one quotient bit per cycle.
// Depends on perm_ord_pkg (widths and request/response structs).
module perm_ord_div import perm_ord_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    typedef enum logic {DIV_IDLE, DIV_RUN} div_state_t;

    div_state_t             state_reg;
    logic [DIV_STEP_W-1:0]  step_reg;
    logic [LCM_W-1:0]       quo_reg;
    logic [COUNT_W-1:0]     rem_reg;
    logic [COUNT_W-1:0]     divisor_reg;
    logic                   done_reg;

    logic [COUNT_W:0] shifted;
    logic [COUNT_W:0] diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[LCM_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DIV_IDLE: begin
                    if (div_req.start) begin
                        quo_reg     <= div_req.dividend;
                        rem_reg     <= '0;
                        divisor_reg <= div_req.divisor;
                        step_reg    <= '0;
                        state_reg   <= DIV_RUN;
                    end
                end
                DIV_RUN: begin
                    // dividend bits shift out of the top as quotient bits shift in
                    quo_reg  <= {quo_reg[LCM_W-2:0], fits};
                    rem_reg  <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == DIV_STEP_W'(LCM_W - 1)) begin
                        state_reg <= DIV_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
            endcase
        end
    end

    assign div_rsp.done      = done_reg;
    assign div_rsp.quotient  = quo_reg;
    assign div_rsp.remainder = rem_reg;

endmodule

// ===== hdl/permutation_order.sv =====
// Order of a permutation (LCM of its cycle lengths), loaded one element per word.
// Input channel s_*: one word per element, s_target_index is the target position for
// that position, s_last_element marks the final word. Words load at one per cycle while s_ready is high.
// Output channel m_*: one word per permutation, sent after the final element:
// m_round_count (saturates at all ones, zero on error) and m_error_code
// (0 ok, 1 index out of range, 2 duplicate target, 3 too many elements).
// After the final element, s_ready stays low until the result word is taken.
// On error the result word is sent in the cycle after the final word. Otherwise the
// design scans the elements and walks each cycle (one mapping-memory read per cycle),
// and for each cycle of length > 1, while the count is not saturated, makes two passes
// of the shared bit-serial divider plus gcd subtract steps and a multiply.
// If the receiver stalls, the result word holds on m_* and no new element is taken.
// Reset (aresetn low, synchronous) clears all control and per-load state; the
// mapping memory is not cleared, only entries written in the current load are read.
module permutation_order import perm_ord_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [TARGET_W-1:0] s_target_index,
    input  logic                s_last_element,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [LCM_W-1:0]    m_round_count,
    output logic [ERR_W-1:0]    m_error_code
);

    typedef enum logic [2:0] {
        ST_LOAD, ST_SCAN, ST_WALK, ST_MOD, ST_GCD, ST_DIV, ST_MUL, ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    logic [TARGET_W-1:0]     map_mem [MAX_ELEMENTS];
    logic [TARGET_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;

    logic [TARGET_SPAN-1:0]  seen_reg, seen_next;
    logic [MAX_ELEMENTS-1:0] visited_reg, visited_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [TARGET_W-1:0]     max_reg, max_next;
    logic [ERR_W-1:0]        latch_reg, latch_next;
    logic [LCM_W-1:0]        lcm_reg, lcm_next;
    logic [COUNT_W-1:0]      scan_reg, scan_next;
    logic [IDX_W-1:0]        walk_start_reg, walk_start_next;
    logic [COUNT_W-1:0]      len_reg, len_next;
    logic [COUNT_W-1:0]      gcd_a_reg, gcd_a_next;
    logic [COUNT_W-1:0]      gcd_b_reg, gcd_b_next;
    logic                    div_start_reg, div_start_next;
    logic [COUNT_W-1:0]      div_divisor_reg, div_divisor_next;
    logic                    m_valid_reg, m_valid_next;
    logic [LCM_W-1:0]        m_round_count_reg, m_round_count_next;
    logic [ERR_W-1:0]        m_error_code_reg, m_error_code_next;

    logic                    store_ok;
    logic [ERR_W-1:0]        load_code;
    logic [IDX_W-1:0]        walk_ptr;
    logic [IDX_W-1:0]        scan_idx;
    logic [LCM_W+COUNT_W-1:0] prod;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = lcm_reg;
    assign div_req.divisor  = div_divisor_reg;

    perm_ord_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    assign s_ready       = (state_reg == ST_LOAD);
    assign m_valid       = m_valid_reg;
    assign m_round_count = m_round_count_reg;
    assign m_error_code  = m_error_code_reg;

    assign store_ok = count_reg < COUNT_W'(MAX_ELEMENTS);
    assign walk_ptr = IDX_W'(rd_data_reg);
    assign scan_idx = scan_reg[IDX_W-1:0];
    assign rd_addr  = (state_reg == ST_WALK) ? walk_ptr : scan_idx;
    assign prod     = (LCM_W+COUNT_W)'(div_rsp.quotient) * (LCM_W+COUNT_W)'(len_reg);

    // mapping store: one write port during load, one registered read port for the scan and the walk
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && s_valid && store_ok) begin
            map_mem[count_reg[IDX_W-1:0]] <= s_target_index;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    always_comb begin
        state_next         = state_reg;
        seen_next          = seen_reg;
        visited_next       = visited_reg;
        count_next         = count_reg;
        max_next           = max_reg;
        latch_next         = latch_reg;
        lcm_next           = lcm_reg;
        scan_next          = scan_reg;
        walk_start_next    = walk_start_reg;
        len_next           = len_reg;
        gcd_a_next         = gcd_a_reg;
        gcd_b_next         = gcd_b_reg;
        div_start_next     = 1'b0;
        div_divisor_next   = div_divisor_reg;
        m_valid_next       = m_valid_reg;
        m_round_count_next = m_round_count_reg;
        m_error_code_next  = m_error_code_reg;
        load_code          = ERR_OK;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (store_ok) begin
                        count_next                = count_reg + 1'b1;
                        seen_next[s_target_index] = 1'b1;
                        if (seen_reg[s_target_index] && latch_reg == ERR_OK) begin
                            latch_next = ERR_DUP;
                        end
                        if (s_target_index > max_reg) begin
                            max_next = s_target_index;
                        end
                    end else begin
                        latch_next = ERR_FULL;
                    end
                    if (s_last_element) begin
                        // full beats range, range beats duplicate
                        priority if (latch_next == ERR_FULL) begin
                            load_code = ERR_FULL;
                        end else if (32'(max_next) >= 32'(count_next)) begin
                            load_code = ERR_RANGE;
                        end else begin
                            load_code = latch_next;
                        end
                        if (load_code == ERR_OK) begin
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end else begin
                            m_valid_next       = 1'b1;
                            m_round_count_next = '0;
                            m_error_code_next  = load_code;
                            state_next         = ST_RESULT;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (scan_reg == count_reg) begin
                    m_valid_next       = 1'b1;
                    m_round_count_next = lcm_reg;
                    m_error_code_next  = ERR_OK;
                    state_next         = ST_RESULT;
                end else if (visited_reg[scan_idx]) begin
                    scan_next = scan_reg + 1'b1;
                end else begin
                    visited_next[scan_idx] = 1'b1;
                    walk_start_next        = scan_idx;
                    len_next               = COUNT_W'(1);
                    state_next             = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_ptr == walk_start_reg) begin
                    // a cycle of length one, or a saturated count, leaves the lcm unchanged
                    if (&lcm_reg || len_reg == COUNT_W'(1)) begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        div_start_next   = 1'b1;
                        div_divisor_next = len_reg;
                        state_next       = ST_MOD;
                    end
                end else begin
                    visited_next[walk_ptr] = 1'b1;
                    len_next               = len_reg + 1'b1;
                end
            end
            ST_MOD: begin
                if (div_rsp.done) begin
                    gcd_a_next = len_reg;
                    gcd_b_next = div_rsp.remainder;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                priority if (gcd_b_reg == '0) begin
                    div_start_next   = 1'b1;
                    div_divisor_next = gcd_a_reg;
                    state_next       = ST_DIV;
                end else if (gcd_a_reg < gcd_b_reg) begin
                    gcd_a_next = gcd_b_reg;
                    gcd_b_next = gcd_a_reg;
                end else begin
                    gcd_a_next = gcd_a_reg - gcd_b_reg;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (|prod[LCM_W+COUNT_W-1:LCM_W]) begin
                    lcm_next = '1;
                end else begin
                    lcm_next = prod[LCM_W-1:0];
                end
                scan_next  = scan_reg + 1'b1;
                state_next = ST_SCAN;
            end
            ST_RESULT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    seen_next    = '0;
                    visited_next = '0;
                    count_next   = '0;
                    max_next     = '0;
                    latch_next   = ERR_OK;
                    lcm_next     = LCM_W'(1);
                    state_next   = ST_LOAD;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            seen_reg      <= '0;
            visited_reg   <= '0;
            count_reg     <= '0;
            max_reg       <= '0;
            latch_reg     <= ERR_OK;
            lcm_reg       <= LCM_W'(1);
            scan_reg      <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            visited_reg   <= visited_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            latch_reg     <= latch_next;
            lcm_reg       <= lcm_next;
            scan_reg      <= scan_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
        end
        walk_start_reg    <= walk_start_next;
        len_reg           <= len_next;
        gcd_a_reg         <= gcd_a_next;
        gcd_b_reg         <= gcd_b_next;
        div_divisor_reg   <= div_divisor_next;
        m_round_count_reg <= m_round_count_next;
        m_error_code_reg  <= m_error_code_next;
    end

endmodule

// ===== bench/permutation_order_tb.sv =====
// Self-checking bench for permutation_order: permutation loads in, order or error code out.
// Needs hdl/perm_ord_pkg.sv, hdl/perm_ord_div.sv and hdl/permutation_order.sv; predicts
// each result from its own copy of the per-load state, or takes it from typed preset words.
module permutation_order_tb import perm_ord_pkg::*; ();

    localparam int ITEMS_WANTED  = 500;
    localparam int LOADS_WANTED  = 40;
    localparam int IDLE_LIMIT    = 40000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int LONG_HOLD     = 400;
    localparam logic [LCM_W-1:0] ALL_ONES = {LCM_W{1'b1}};

    typedef struct packed {
        logic [TARGET_W-1:0] tgt;
        logic                last_el;
        logic                typed;    // count/code below are the expected result
        logic [LCM_W-1:0]    count;
        logic [ERR_W-1:0]    code;
    } elem_word_t;

    typedef struct packed {
        logic [LCM_W-1:0] count;
        logic [ERR_W-1:0] code;
    } order_result_t;

    localparam int PRESET_LEN = 18;
    localparam elem_word_t PRESET_LOADS [PRESET_LEN] = '{
        // single fixed point
        '{6'd0,  1'b1, 1'b1, 64'd1, ERR_OK},
        // one swap
        '{6'd1,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd0,  1'b1, 1'b1, 64'd2, ERR_OK},
        // top index on a one-element load
        '{6'd63, 1'b1, 1'b1, 64'd0, ERR_RANGE},
        // duplicate target
        '{6'd0,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd0,  1'b1, 1'b1, 64'd0, ERR_DUP},
        // duplicate and out of range together: range wins
        '{6'd1,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd1,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd5,  1'b1, 1'b1, 64'd0, ERR_RANGE},
        // rotation of positions 0 to 2 plus a swap of positions 3 and 4
        '{6'd1,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd2,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd0,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd4,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd3,  1'b1, 1'b0, 64'd0, ERR_OK},
        // identity
        '{6'd0,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd1,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd2,  1'b0, 1'b0, 64'd0, ERR_OK},
        '{6'd3,  1'b1, 1'b1, 64'd1, ERR_OK}
    };

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [TARGET_W-1:0] s_target_index = '0;
    logic                s_last_element = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [LCM_W-1:0]    m_round_count;
    logic [ERR_W-1:0]    m_error_code;

    permutation_order dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_index (s_target_index),
        .s_last_element (s_last_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_round_count  (m_round_count),
        .m_error_code   (m_error_code)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state for the load in progress
    logic [TARGET_W-1:0] load_map [MAX_ELEMENTS];
    bit                  load_seen [TARGET_SPAN];
    int                  load_count = 0;
    logic [ERR_W-1:0]    load_err = ERR_OK;

    elem_word_t          feed_q [$];
    order_result_t       pending_orders [$];
    logic [TARGET_W-1:0] load_buf [$];
    int                  cyc_len [$];

    elem_word_t on_bus;
    elem_word_t next_word;
    int         burst_left;
    int         gap_left;
    int         hold_left;
    bit         hold_used;
    int         rdy_mode;
    int         mode_left;
    int         results_taken;
    int         fail_cnt = 0;
    int         idle_cycles = 0;

    function automatic void order_predict(input logic [TARGET_W-1:0] tgt, input logic last_el,
                                          output bit has_res, output order_result_t res);
        int               n, p;
        logic [LCM_W-1:0] len, acc, a, b, r, q;
        bit               visited [MAX_ELEMENTS];
        has_res = 1'b0;
        res     = '{count: '0, code: ERR_OK};
        if (load_count >= MAX_ELEMENTS) begin
            load_err = ERR_FULL;   // word dropped
        end else begin
            load_map[load_count] = tgt;
            load_count++;
            if (load_seen[tgt] && load_err == ERR_OK)
                load_err = ERR_DUP;
            load_seen[tgt] = 1'b1;
        end
        if (!last_el)
            return;

        has_res  = 1'b1;
        n        = load_count;
        res.code = load_err;
        if (res.code != ERR_FULL) begin
            for (int i = 0; i < n; i++)
                if (load_map[i] >= n)
                    res.code = ERR_RANGE;
        end
        if (res.code == ERR_OK) begin
            acc = 1;
            for (int i = 0; i < n; i++) begin
                if (!visited[i]) begin
                    p   = i;
                    len = 0;
                    while (!visited[p]) begin
                        visited[p] = 1'b1;
                        len++;
                        p = load_map[p];
                    end
                    if (acc != ALL_ONES && len != 0) begin
                        a = acc;
                        b = len;
                        while (b != 0) begin
                            r = a % b;
                            a = b;
                            b = r;
                        end
                        q = acc / a;
                        acc = (q > ALL_ONES / len) ? ALL_ONES : q * len;
                    end
                end
            end
            res.count = acc;
        end

        load_count = 0;
        load_err   = ERR_OK;
        foreach (load_seen[k])
            load_seen[k] = 1'b0;
    endfunction

    task automatic pick_lengths(input int n);
        int rem, l;
        cyc_len.delete();
        rem = n;
        while (rem > 0) begin
            l = $urandom_range(1, rem);
            cyc_len.insert(cyc_len.size(), l);
            rem -= l;
        end
    endtask

    // lay the cycle lengths over a shuffled set of positions
    task automatic make_cycles();
        int                  total, base, t, tmp;
        int                  ord [MAX_ELEMENTS];
        logic [TARGET_W-1:0] perm_img [MAX_ELEMENTS];
        total = 0;
        foreach (cyc_len[c])
            total += cyc_len[c];
        for (int k = 0; k < total; k++)
            ord[k] = k;
        for (int k = total - 1; k > 0; k--) begin
            t      = $urandom_range(0, k);
            tmp    = ord[k];
            ord[k] = ord[t];
            ord[t] = tmp;
        end
        base = 0;
        foreach (cyc_len[c]) begin
            for (int k = 0; k < cyc_len[c]; k++)
                perm_img[ord[base + k]] = TARGET_W'(ord[base + (k + 1) % cyc_len[c]]);
            base += cyc_len[c];
        end
        load_buf.delete();
        for (int k = 0; k < total; k++)
            load_buf.insert(load_buf.size(), perm_img[k]);
    endtask

    task automatic queue_load();
        elem_word_t w;
        foreach (load_buf[k]) begin
            w = '{tgt: load_buf[k], last_el: (k == load_buf.size() - 1),
                  typed: 1'b0, count: '0, code: ERR_OK};
            feed_q.insert(feed_q.size(), w);
        end
    endtask

    // sender: bursts of random length, random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0 || feed_q.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end else begin
                next_word = feed_q.pop_front();
                s_valid        <= 1'b1;
                s_target_index <= next_word.tgt;
                s_last_element <= next_word.last_el;
                on_bus         <= next_word;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: stall pattern changes mode now and then; one long hold-off early on
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
            rdy_mode  <= 0;
            mode_left <= 0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_used && results_taken == 6) begin
            hold_used <= 1'b1;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rdy_mode  <= $urandom_range(0, 2);
                mode_left <= $urandom_range(20, 150);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rdy_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // result check first, then predict from the input word taken at this edge
    always @(posedge aclk) begin : scoreboard
        bit            got;
        order_result_t res, want;
        if (!aresetn) begin
            results_taken <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_taken <= results_taken + 1;
                if (pending_orders.size() == 0) begin
                    $error("unexpected result word: round_count=%0d error_code=%0d",
                           m_round_count, m_error_code);
                    fail_cnt++;
                end else begin
                    want = pending_orders.pop_front();
                    if (m_round_count !== want.count) begin
                        $error("round_count: expected %0d, got %0d", want.count, m_round_count);
                        fail_cnt++;
                    end
                    if (m_error_code !== want.code) begin
                        $error("error_code: expected %0d, got %0d", want.code, m_error_code);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                order_predict(on_bus.tgt, on_bus.last_el, got, res);
                if (got) begin
                    if (on_bus.typed) begin
                        want.count = on_bus.count;
                        want.code  = on_bus.code;
                    end else begin
                        want = res;
                    end
                    pending_orders.insert(pending_orders.size(), want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : main
        int kind, n, i, j, span, items, loads;
        items = 0;
        loads = 0;
        foreach (PRESET_LOADS[k])
            feed_q.insert(feed_q.size(), PRESET_LOADS[k]);

        while (items < ITEMS_WANTED || loads < LOADS_WANTED) begin
            kind = $urandom_range(0, 99);
            load_buf.delete();
            if (kind < 45) begin
                pick_lengths($urandom_range(1, 12));
                make_cycles();
            end else if (kind < 49) begin
                // prime cycle lengths: large order
                cyc_len = '{2, 3, 5, 7, 11, 13, 17};
                repeat ($urandom_range(0, 6))
                    cyc_len.insert(cyc_len.size(), 1);
                make_cycles();
            end else if (kind < 52) begin
                pick_lengths(MAX_ELEMENTS);
                make_cycles();
            end else if (kind < 67) begin
                pick_lengths($urandom_range(2, 12));
                make_cycles();
                n = load_buf.size();
                i = $urandom_range(0, n - 1);
                j = (i + $urandom_range(1, n - 1)) % n;
                load_buf[i] = load_buf[j];
            end else if (kind < 80) begin
                pick_lengths($urandom_range(1, 12));
                make_cycles();
                n = load_buf.size();
                load_buf[$urandom_range(0, n - 1)] =
                    TARGET_W'($urandom_range(n, TARGET_SPAN - 1));
            end else if (kind < 96) begin
                n    = $urandom_range(1, 12);
                span = $urandom_range(0, 1) ? n - 1 : TARGET_SPAN - 1;
                repeat (n)
                    load_buf.insert(load_buf.size(), TARGET_W'($urandom_range(0, span)));
            end else begin
                // overfull load
                repeat ($urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4))
                    load_buf.insert(load_buf.size(),
                                    TARGET_W'($urandom_range(0, TARGET_SPAN - 1)));
            end
            items += load_buf.size();
            loads++;
            queue_load();
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (feed_q.size() != 0 || s_valid || pending_orders.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
